@@ rtl/core/hmp_pkg.sv @@
`default_nettype none

package hmp_pkg;

	// Block geometry and padding constants
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned WIDX_W      = 4;
	localparam int unsigned BLK_W       = 16;
	localparam int unsigned OUT_W       = 32;
	localparam int unsigned LEN_W       = 32;

	localparam logic [WIDX_W-1:0] LAST_WIDX     = WIDX_W'(BLOCK_WORDS - 1);
	localparam logic [WIDX_W-1:0] PRE_LAST_WIDX = WIDX_W'(BLOCK_WORDS - 2);
	localparam logic [7:0]        PAD_BYTE      = 8'h80;
	localparam logic [LEN_W-1:0]  LEN_STEP      = LEN_W'(8);

	// Request codes
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Input word
	typedef struct packed {
		logic       req_type;
		logic [7:0] byte_value;
	} req_t;

	// Output word
	typedef struct packed {
		logic [OUT_W-1:0]  word_value;
		logic [WIDX_W-1:0] word_num;
		logic [BLK_W-1:0]  block_index;
		logic              last_word;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_byte;  // pack a message byte
		logic take_end;   // close current word with the pad byte
		logic pad_zero;   // load a zero padding word
		logic pad_len;    // load the length word and clear state
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic word_full;  // next byte completes the word
		logic at_last;    // word position is the length slot
		logic at_pre_last;// word position is the slot before it
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/core/hmp_ctrl.sv @@
`default_nettype none

module hmp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire logic           req_type,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output hmp_pkg::cmd_t       cmd,
	input  wire hmp_pkg::sts_t  sts
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PAD  = 2'b10
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   final_q;     // padding has reached the block that holds the length
	logic   slot_free;
	logic   req_acc;
	logic   loads;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && slot_free);
	assign req_acc   = req_valid && !req_stall;

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.take_byte = req_acc && (req_type == hmp_pkg::REQ_BYTE);
		cmd.take_end  = req_acc && (req_type == hmp_pkg::REQ_END);
		if ((state_q == ST_PAD) && slot_free) begin
			if (sts.at_last && final_q) begin
				cmd.pad_len = 1'b1;
			end else begin
				cmd.pad_zero = 1'b1;
			end
		end
	end

	assign loads = (cmd.take_byte && sts.word_full) || cmd.take_end ||
	               cmd.pad_zero || cmd.pad_len;

	// State machine and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			if (loads) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.take_end) begin
						state_q <= ST_PAD;
						final_q <= !sts.at_pre_last;
					end
				end
				ST_PAD: begin
					if (cmd.pad_len) begin
						state_q <= ST_IDLE;
						final_q <= 1'b0;
					end else if (cmd.pad_zero && sts.at_last) begin
						final_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/hmp_datapath.sv @@
`default_nettype none

module hmp_datapath #(
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     byte_value,
	input  wire hmp_pkg::cmd_t  cmd,
	output hmp_pkg::sts_t       sts,
	output hmp_pkg::rsp_t       rsp
);

	localparam int unsigned BPW    = WORD_BITS / 8;
	localparam int unsigned BPOS_W = (BPW > 1) ? $clog2(BPW) : 1;
	localparam int unsigned SH_W   = BPOS_W + 3;
	localparam int unsigned LANE_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0]           acc_q;
	logic [BPOS_W-1:0]              bpos_q;
	logic [hmp_pkg::WIDX_W-1:0]     wpos_q;
	logic [hmp_pkg::BLK_W-1:0]      blk_q;
	logic [hmp_pkg::LEN_W-1:0]      len_q;
	hmp_pkg::rsp_t                  rsp_q;

	logic [7:0]                     put_byte;
	logic [SH_W-1:0]                shift;
	logic [WORD_BITS-1:0]           acc_next;
	logic [hmp_pkg::WIDX_W-1:0]     wpos_inc;

	// Byte insert, first byte highest
	assign put_byte = cmd.take_end ? hmp_pkg::PAD_BYTE : byte_value;
	assign shift    = {(BPOS_W'(BPW - 1) - bpos_q), 3'b000};
	assign acc_next = acc_q | (WORD_BITS'(put_byte) << LANE_W'(shift));
	assign wpos_inc = wpos_q + 1'b1;

	assign sts.word_full   = (bpos_q == BPOS_W'(BPW - 1));
	assign sts.at_last     = (wpos_q == hmp_pkg::LAST_WIDX);
	assign sts.at_pre_last = (wpos_q == hmp_pkg::PRE_LAST_WIDX);

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bpos_q <= '0;
			wpos_q <= '0;
			blk_q  <= '0;
			len_q  <= '0;
		end else if (cmd.take_byte) begin
			len_q <= len_q + hmp_pkg::LEN_STEP;
			if (sts.word_full) begin
				acc_q  <= '0;
				bpos_q <= '0;
				wpos_q <= wpos_inc;
				if (sts.at_last) begin
					blk_q <= blk_q + 1'b1;
				end
			end else begin
				acc_q  <= acc_next;
				bpos_q <= bpos_q + 1'b1;
			end
		end else if (cmd.take_end) begin
			// word/block regs now count the padding words
			acc_q  <= '0;
			bpos_q <= '0;
			wpos_q <= wpos_inc;
			if (sts.at_last) begin
				blk_q <= blk_q + 1'b1;
			end
		end else if (cmd.pad_zero) begin
			wpos_q <= wpos_inc;
			if (sts.at_last) begin
				blk_q <= blk_q + 1'b1;
			end
		end else if (cmd.pad_len) begin
			acc_q  <= '0;
			bpos_q <= '0;
			wpos_q <= '0;
			blk_q  <= '0;
			len_q  <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if ((cmd.take_byte && sts.word_full) || cmd.take_end) begin
			rsp_q.word_value  <= acc_next[hmp_pkg::OUT_W-1:0];
			rsp_q.word_num    <= wpos_q;
			rsp_q.block_index <= blk_q;
			rsp_q.last_word   <= 1'b0;
		end else if (cmd.pad_zero) begin
			rsp_q.word_value  <= '0;
			rsp_q.word_num    <= wpos_q;
			rsp_q.block_index <= blk_q;
			rsp_q.last_word   <= 1'b0;
		end else if (cmd.pad_len) begin
			rsp_q.word_value  <= len_q;
			rsp_q.word_num    <= wpos_q;
			rsp_q.block_index <= blk_q;
			rsp_q.last_word   <= 1'b1;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

@@ rtl/core/hash_message_padder_core.sv @@
// Message padder for a 16-word block hash.
// Request channel (req_valid/req_stall/req_data): one word per message byte
// (req_type 0) or an end-of-message word (req_type 1, byte ignored).
// Response channel (rsp_valid/rsp_stall/rsp_data): packed block words with
// word and block index; last_word marks the length word that ends a message.
// Bytes are taken one per cycle while not stalled; a byte that completes a
// word shows that word on rsp in the next cycle, from the output register.
// An end word yields 3 to 18 response words, one per cycle while not stalled:
// the word holding the 0x80 byte, zero words, and the bit length in word 15.
// Requests are held off (req_stall high) until the length word is loaded.
// A stalled response holds its word; req_stall stays high while a loaded
// word waits on rsp_stall.
// Reset clears the packing state and drops rsp_valid; the next byte starts
// a new message in block 0.
`default_nettype none

module hash_message_padder_core #(
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire hmp_pkg::req_t  req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output hmp_pkg::rsp_t       rsp_data
);

	hmp_pkg::cmd_t cmd;
	hmp_pkg::sts_t sts;

	hmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_data.req_type),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	hmp_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (req_data.byte_value),
		.cmd        (cmd),
		.sts        (sts),
		.rsp        (rsp_data)
	);

endmodule

`default_nettype wire
